// ----- rtl/core/smb_pkg.sv -----
// ----------------------------------------------------------------------------
// smb_pkg
// types, phase codes and stage codes for the smbus master
// ----------------------------------------------------------------------------
package smb_pkg;

    localparam int PhW = 4;
    localparam logic [PhW-1:0] PH_IDLE    = 4'd0;
    localparam logic [PhW-1:0] PH_RS_DLY  = 4'd1;
    localparam logic [PhW-1:0] PH_RS_HI   = 4'd2;
    localparam logic [PhW-1:0] PH_RS_DLY2 = 4'd3;
    localparam logic [PhW-1:0] PH_ST_CHK  = 4'd4;
    localparam logic [PhW-1:0] PH_ST_DLY  = 4'd5;
    localparam logic [PhW-1:0] PH_B_DLY1  = 4'd6;
    localparam logic [PhW-1:0] PH_B_HI    = 4'd7;
    localparam logic [PhW-1:0] PH_B_DLY2  = 4'd8;
    localparam logic [PhW-1:0] PH_SP_DLY1 = 4'd9;
    localparam logic [PhW-1:0] PH_SP_HI   = 4'd10;
    localparam logic [PhW-1:0] PH_SP_DLY2 = 4'd11;
    localparam logic [PhW-1:0] PH_SP_CHK  = 4'd12;
    localparam logic [PhW-1:0] PH_SP_DLY3 = 4'd13;

    localparam logic [2:0] SG_ADDR_W = 3'd0;
    localparam logic [2:0] SG_CMD    = 3'd1;
    localparam logic [2:0] SG_DATA   = 3'd2;
    localparam logic [2:0] SG_ADDR_R = 3'd3;
    localparam logic [2:0] SG_READ   = 3'd4;

    localparam logic [2:0] MODE_WR_BYTE = 3'd1;
    localparam logic [2:0] MODE_RD_BYTE = 3'd2;
    localparam logic [2:0] MODE_BLK_WR  = 3'd3;
    localparam logic [2:0] MODE_BLK_RD  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NACK = 2'd1;
    localparam logic [1:0] ST_ARB  = 2'd2;

    localparam logic [15:0] BIT_DELAY_RST = 16'd5;
    localparam logic [7:0]  MSB_MASK      = 8'h80;
    localparam logic [1:0]  ADDR_BIT_DELAY = 2'd0;

    typedef struct packed {
        logic       scl_in;
        logic       sda_in;
        logic [2:0] mode;
        logic [6:0] dev_addr;
        logic [7:0] command_code;
        logic [7:0] length;
        logic [7:0] wr_data;
    } t_in;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       wr_taken;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       done_res;
        logic [1:0] status;
    } t_out;

endpackage

// ----- rtl/core/smb_if.sv -----
// ----------------------------------------------------------------------------
// smb_in_if / smb_out_if
// valid/ready channels carrying one tick word each way
// ----------------------------------------------------------------------------
interface smb_in_if;
    logic          valid;
    logic          ready;
    smb_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smb_out_if;
    logic          valid;
    logic          ready;
    smb_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/smb_regs.sv -----
// ----------------------------------------------------------------------------
// smb_regs
// apb register file holding the half-bit delay
// ----------------------------------------------------------------------------
module smb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_bit_delay
);
    logic [15:0] r_bit_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_delay <= smb_pkg::BIT_DELAY_RST;
        end else if (psel && penable && pwrite && paddr == smb_pkg::ADDR_BIT_DELAY) begin
            r_bit_delay <= pwdata[15:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr == smb_pkg::ADDR_BIT_DELAY) ? {16'd0, r_bit_delay} : 32'd0;
    assign o_bit_delay = r_bit_delay;
endmodule

// ----- rtl/core/smbus_bitbang_master_core.sv -----
// ----------------------------------------------------------------------------
// smbus_bitbang_master_core
// open-drain i2c master running one smbus transaction per request
//
// channel  dir  word
// in_ch    in   sampled scl/sda, request and write data, one tick
// out_ch   out  line drives, handshake strobes, read data, status
// apb      in   bit_delay register
//
// one tick per cycle while the output is not stalled: the tick is processed in the cycle it is accepted
// and the result word lands in the output register on the same edge.
// a tick is accepted whenever the output register is empty or being taken.
// synchronous active-low reset returns the bus to idle with lines released.
// ----------------------------------------------------------------------------
module smbus_bitbang_master_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smb_in_if.sink      in_ch,
    smb_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] bit_delay;

    smb_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_bit_delay(bit_delay)
    );

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_dcnt, n_dcnt;
    logic [3:0]  r_bidx, n_bidx;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_byidx, n_byidx;
    logic        r_started, n_started;
    logic [2:0]  r_mode, n_mode;
    logic [6:0]  r_addr, n_addr;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [2:0]  r_stage, n_stage;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_nack, n_nack;
    logic [1:0]  r_err, n_err;
    logic        r_ovalid;
    smb_pkg::t_out r_out, n_out;

    logic accept;
    assign in_ch.ready  = !r_ovalid || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    smb_pkg::t_in d;
    assign d = in_ch.data;

    logic [15:0] lim, dinc;
    logic        dover;
    assign lim   = (bit_delay == 16'd0) ? 16'd1 : bit_delay;
    assign dinc  = r_dcnt + 16'd1;
    assign dover = dinc >= lim;

    logic [7:0] rcount;
    assign rcount = (r_mode == smb_pkg::MODE_RD_BYTE) ? 8'd1 : r_len;

    always_comb begin
        logic       rdb, isack, wb, ackv, do_stop, do_byte, do_bit, do_start;
        logic [2:0] sg, mreq;
        logic [7:0] bnext, wbyte, lastcnt;
        logic [3:0] bidx;
        n_phase = r_phase; n_dcnt = r_dcnt; n_bidx = r_bidx; n_shift = r_shift;
        n_byidx = r_byidx; n_started = r_started; n_mode = r_mode; n_addr = r_addr;
        n_cmd = r_cmd; n_len = r_len; n_stage = r_stage; n_scl = r_scl;
        n_sda = r_sda; n_nack = r_nack; n_err = r_err;
        n_out = '0;
        do_stop = 1'b0; do_byte = 1'b0; do_bit = 1'b0; do_start = 1'b0; ackv = 1'b0;
        sg = smb_pkg::SG_ADDR_W; wbyte = 8'd0; bnext = r_byidx;
        rdb = r_stage == smb_pkg::SG_READ;
        isack = r_bidx >= 4'd8;
        wb = rdb == isack;
        bidx = r_bidx + 4'd1;
        mreq = r_mode;
        lastcnt = rcount;
        case (r_phase)
            smb_pkg::PH_IDLE: begin
                if (d.mode >= smb_pkg::MODE_WR_BYTE && d.mode <= smb_pkg::MODE_BLK_RD) begin
                    n_mode = d.mode; n_addr = d.dev_addr; n_cmd = d.command_code;
                    n_len = d.length; n_byidx = 8'd0; n_nack = 1'b0; n_err = smb_pkg::ST_OK;
                    do_byte = 1'b1; sg = smb_pkg::SG_ADDR_W;
                end
            end
            smb_pkg::PH_RS_DLY: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin n_scl = 1'b0; n_phase = smb_pkg::PH_RS_HI; end
            end
            smb_pkg::PH_RS_HI: begin
                if (d.scl_in) begin n_dcnt = 16'd0; n_phase = smb_pkg::PH_RS_DLY2; end
            end
            smb_pkg::PH_RS_DLY2: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) n_phase = smb_pkg::PH_ST_CHK;
            end
            smb_pkg::PH_ST_CHK: begin
                if (!d.sda_in) begin
                    n_err = smb_pkg::ST_ARB; n_scl = 1'b1; do_stop = 1'b1;
                end else begin
                    n_sda = 1'b1; n_dcnt = 16'd0; n_phase = smb_pkg::PH_ST_DLY;
                end
            end
            smb_pkg::PH_ST_DLY: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin
                    n_scl = 1'b1; n_started = 1'b1; n_bidx = 4'd0; do_bit = 1'b1;
                end
            end
            smb_pkg::PH_B_DLY1: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin n_scl = 1'b0; n_phase = smb_pkg::PH_B_HI; end
            end
            smb_pkg::PH_B_HI: begin
                if (d.scl_in) begin
                    if (wb && !r_sda && !d.sda_in) begin
                        n_err = smb_pkg::ST_ARB; n_scl = 1'b1; do_stop = 1'b1;
                    end else begin
                        if (!wb) begin
                            if (isack) n_nack = d.sda_in;
                            else n_shift = {r_shift[6:0], d.sda_in};
                        end else if (!isack) begin
                            n_shift = {r_shift[6:0], 1'b0};
                        end
                        n_dcnt = 16'd0; n_phase = smb_pkg::PH_B_DLY2;
                    end
                end
            end
            smb_pkg::PH_B_DLY2: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin
                    n_scl = 1'b1; n_bidx = bidx;
                    if (bidx < 4'd9) begin
                        do_bit = 1'b1;
                    end else if (!rdb && r_nack) begin
                        n_err = smb_pkg::ST_NACK; do_stop = 1'b1;
                    end else begin
                        case (r_stage)
                            smb_pkg::SG_ADDR_W: begin do_byte = 1'b1; sg = smb_pkg::SG_CMD; end
                            smb_pkg::SG_CMD: begin
                                if (mreq == smb_pkg::MODE_WR_BYTE ||
                                    (mreq == smb_pkg::MODE_BLK_WR && r_len != 8'd0)) begin
                                    do_byte = 1'b1; sg = smb_pkg::SG_DATA; wbyte = d.wr_data;
                                end else if (mreq == smb_pkg::MODE_BLK_WR) begin
                                    do_stop = 1'b1;
                                end else begin
                                    do_byte = 1'b1; sg = smb_pkg::SG_ADDR_R;
                                end
                            end
                            smb_pkg::SG_DATA: begin
                                bnext = r_byidx + 8'd1; n_byidx = bnext;
                                if (mreq == smb_pkg::MODE_WR_BYTE || bnext >= r_len) begin
                                    do_stop = 1'b1;
                                end else begin
                                    do_byte = 1'b1; sg = smb_pkg::SG_DATA; wbyte = d.wr_data;
                                end
                            end
                            smb_pkg::SG_ADDR_R: begin
                                if (mreq == smb_pkg::MODE_BLK_RD && r_len == 8'd0) do_stop = 1'b1;
                                else begin do_byte = 1'b1; sg = smb_pkg::SG_READ; end
                            end
                            default: begin
                                n_out.rd_data = r_shift; n_out.rd_valid = 1'b1;
                                bnext = r_byidx + 8'd1; n_byidx = bnext;
                                if (bnext >= lastcnt) do_stop = 1'b1;
                                else begin do_byte = 1'b1; sg = smb_pkg::SG_READ; end
                            end
                        endcase
                    end
                end
            end
            smb_pkg::PH_SP_DLY1: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin n_scl = 1'b0; n_phase = smb_pkg::PH_SP_HI; end
            end
            smb_pkg::PH_SP_HI: begin
                if (d.scl_in) begin n_dcnt = 16'd0; n_phase = smb_pkg::PH_SP_DLY2; end
            end
            smb_pkg::PH_SP_DLY2: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin n_sda = 1'b0; n_phase = smb_pkg::PH_SP_CHK; end
            end
            smb_pkg::PH_SP_CHK: begin
                if (!d.sda_in) begin
                    n_err = smb_pkg::ST_ARB; n_phase = smb_pkg::PH_IDLE;
                    n_out.done_res = 1'b1; n_out.status = smb_pkg::ST_ARB;
                end else begin
                    n_dcnt = 16'd0; n_phase = smb_pkg::PH_SP_DLY3;
                end
            end
            smb_pkg::PH_SP_DLY3: begin
                n_dcnt = dover ? 16'd0 : dinc;
                if (dover) begin
                    n_started = 1'b0; n_phase = smb_pkg::PH_IDLE;
                    n_out.done_res = 1'b1; n_out.status = r_err;
                end
            end
            default: n_phase = smb_pkg::PH_IDLE;
        endcase

        if (do_byte) begin
            n_stage = sg; n_bidx = 4'd0;
            case (sg)
                smb_pkg::SG_ADDR_W: n_shift = {(r_phase == smb_pkg::PH_IDLE) ? d.dev_addr
                                                                          : r_addr, 1'b0};
                smb_pkg::SG_ADDR_R: n_shift = {r_addr, 1'b1};
                smb_pkg::SG_CMD:    n_shift = r_cmd;
                smb_pkg::SG_DATA:   begin n_shift = wbyte; n_out.wr_taken = 1'b1; end
                default:            n_shift = 8'd0;
            endcase
            if (sg == smb_pkg::SG_ADDR_W || sg == smb_pkg::SG_ADDR_R) do_start = 1'b1;
            else do_bit = 1'b1;
        end
        if (do_start) begin
            n_dcnt = 16'd0;
            if (r_started) begin n_sda = 1'b0; n_phase = smb_pkg::PH_RS_DLY; end
            else n_phase = smb_pkg::PH_ST_CHK;
        end
        if (do_bit) begin
            rdb = n_stage == smb_pkg::SG_READ;
            isack = n_bidx >= 4'd8;
            if (rdb != isack) begin
                n_sda = 1'b0;
            end else begin
                ackv = (n_byidx + 8'd1) >= lastcnt;
                n_sda = isack ? !ackv : !((n_shift & smb_pkg::MSB_MASK) != 8'd0);
            end
            n_dcnt = 16'd0; n_phase = smb_pkg::PH_B_DLY1;
        end
        if (do_stop) begin
            n_sda = 1'b1; n_dcnt = 16'd0; n_phase = smb_pkg::PH_SP_DLY1;
        end
        n_out.scl_low  = n_scl;
        n_out.sda_low  = n_sda;
        n_out.busy_res = n_phase != smb_pkg::PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= smb_pkg::PH_IDLE; r_dcnt <= '0; r_bidx <= '0; r_shift <= '0;
            r_byidx <= '0; r_started <= 1'b0; r_mode <= '0; r_addr <= '0; r_cmd <= '0;
            r_len <= '0; r_stage <= smb_pkg::SG_ADDR_W; r_scl <= 1'b0; r_sda <= 1'b0;
            r_nack <= 1'b0; r_err <= smb_pkg::ST_OK; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_dcnt <= n_dcnt; r_bidx <= n_bidx; r_shift <= n_shift;
                r_byidx <= n_byidx; r_started <= n_started; r_mode <= n_mode;
                r_addr <= n_addr; r_cmd <= n_cmd; r_len <= n_len; r_stage <= n_stage;
                r_scl <= n_scl; r_sda <= n_sda; r_nack <= n_nack; r_err <= n_err;
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end
endmodule
